FILE: sv/ows_pkg.sv
// Package for the one-wire temperature sensor sequencer.
// Holds state and bus operation codes, command bytes and the structs shared between the modules.
// No dependencies.
package ows_pkg;

   // Sequencer states, four-bit code as reported on the result channel
   typedef enum logic [3:0] {
      ST_IDLE       = 4'd0,
      ST_C_RESET    = 4'd1,
      ST_C_SKIP     = 4'd2,
      ST_C_CONV     = 4'd3,
      ST_C_WAIT     = 4'd4,
      ST_R_RESET    = 4'd5,
      ST_R_SKIP     = 4'd6,
      ST_R_CMD      = 4'd7,
      ST_R_RECV     = 4'd8,
      ST_POST_RESET = 4'd9,
      ST_COMPLETE   = 4'd10,
      ST_ERROR      = 4'd11
   } seq_state_type;

   // Bus operations issued per tick
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_RESET = 3'd1,
      OP_WRITE = 3'd2,
      OP_POLL  = 3'd3,
      OP_READ  = 3'd4
   } bus_op_type;

   // Function command bytes
   localparam logic [7:0] CMD_NONE     = 8'h00;
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   // Item action codes
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_START = 1'b1;

   // One input transaction
   typedef struct packed {
      logic       action;
      logic       presence_ok;
      logic       conversion_done;
      logic [7:0] scratch_low_byte;
      logic [7:0] scratch_high_byte;
   } item_type;

   // Architectural state of the sequencer
   typedef struct packed {
      seq_state_type      state;
      logic signed [15:0] temp_tenths;
      logic               busy;
      logic               ready;
      logic               error;
   } seq_regs_type;

   // One result transaction
   typedef struct packed {
      bus_op_type         bus_op;
      logic [7:0]         bus_byte;
      logic               start_accepted;
      logic               busy_res;
      logic               data_ready;
      logic               error;
      logic               complete;
      logic [3:0]         state_code;
      logic signed [15:0] temperature_x10;
   } rsp_type;

endpackage

FILE: sv/ows_in_reg.sv
// Input register stage of the one-wire sequencer.
// Captures one request transaction and holds it until the step logic consumes it.
// Depends on ows_pkg.
module ows_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ows_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output ows_pkg::item_type item
);
   import ows_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // Free when empty or when the held item leaves this cycle
   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

FILE: sv/ows_step.sv
// Next-state and result logic of the one-wire sequencer.
// Purely combinational: one item against the current state gives next state and result.
// Depends on ows_pkg.
module ows_step (
   input  ows_pkg::item_type     item,
   input  ows_pkg::seq_regs_type cur,
   output ows_pkg::seq_regs_type nxt,
   output ows_pkg::rsp_type      rsp
);
   import ows_pkg::*;

   logic signed [15:0] raw;
   logic signed [19:0] prod;
   logic signed [19:0] adj;
   logic signed [15:0] tenths;
   bus_op_type         op;
   logic [7:0]         cmd;
   logic               accepted;

   // raw * 10 / 16, truncating toward zero: bias negatives by 15 before the shift
   assign raw    = {item.scratch_high_byte, item.scratch_low_byte};
   assign prod   = ({{4{raw[15]}}, raw} <<< 3) + ({{4{raw[15]}}, raw} <<< 1);
   assign adj    = prod + (prod[19] ? 20'sd15 : 20'sd0);
   assign tenths = adj[19:4];

   // Sequencer transitions
   always_comb begin
      nxt      = cur;
      op       = OP_NONE;
      cmd      = CMD_NONE;
      accepted = 1'b0;
      if (item.action == ACT_START) begin
         if (!cur.busy) begin
            nxt.state       = ST_C_RESET;
            nxt.temp_tenths = 16'sd0;
            nxt.busy        = 1'b1;
            nxt.ready       = 1'b0;
            nxt.error       = 1'b0;
            accepted        = 1'b1;
         end
      end else begin
         case (cur.state)
            ST_IDLE, ST_COMPLETE, ST_ERROR: begin
               nxt = cur;
            end
            ST_C_RESET, ST_R_RESET: begin
               op = OP_RESET;
               if (item.presence_ok) begin
                  nxt.state = (cur.state == ST_C_RESET) ? ST_C_SKIP : ST_R_SKIP;
               end else begin
                  nxt.state = ST_ERROR;
                  nxt.busy  = 1'b0;
                  nxt.ready = 1'b0;
                  nxt.error = 1'b1;
               end
            end
            ST_C_SKIP: begin
               op        = OP_WRITE;
               cmd       = CMD_SKIP_ROM;
               nxt.state = ST_C_CONV;
            end
            ST_C_CONV: begin
               op        = OP_WRITE;
               cmd       = CMD_CONVERT;
               nxt.state = ST_C_WAIT;
            end
            ST_C_WAIT: begin
               op = OP_POLL;
               if (item.conversion_done) begin
                  nxt.state = ST_R_RESET;
               end
            end
            ST_R_SKIP: begin
               op        = OP_WRITE;
               cmd       = CMD_SKIP_ROM;
               nxt.state = ST_R_CMD;
            end
            ST_R_CMD: begin
               op        = OP_WRITE;
               cmd       = CMD_READ_PAD;
               nxt.state = ST_R_RECV;
            end
            ST_R_RECV: begin
               op              = OP_READ;
               nxt.temp_tenths = tenths;
               nxt.state       = ST_POST_RESET;
            end
            ST_POST_RESET: begin
               op = OP_RESET;
               if (item.presence_ok) begin
                  nxt.state = ST_COMPLETE;
                  nxt.busy  = 1'b0;
                  nxt.ready = 1'b1;
                  nxt.error = 1'b0;
               end else begin
                  nxt.state = ST_ERROR;
                  nxt.busy  = 1'b0;
                  nxt.ready = 1'b0;
                  nxt.error = 1'b1;
               end
            end
            default: begin
               // unreachable code: drop into error
               nxt.state = ST_ERROR;
               nxt.busy  = 1'b0;
               nxt.ready = 1'b0;
               nxt.error = 1'b1;
            end
         endcase
      end
   end

   // Result fields reflect the state after this item
   always_comb begin
      rsp.bus_op          = op;
      rsp.bus_byte        = cmd;
      rsp.start_accepted  = accepted;
      rsp.busy_res        = nxt.busy;
      rsp.data_ready      = nxt.ready;
      rsp.error           = nxt.error;
      rsp.complete        = (nxt.state == ST_COMPLETE) && nxt.ready;
      rsp.state_code      = nxt.state;
      rsp.temperature_x10 = nxt.ready ? nxt.temp_tenths : 16'sd0;
   end

endmodule

FILE: sv/ows_seq_regs.sv
// Sequencer state registers and result register of the one-wire sequencer.
// Commits a step when the result register can take it.
// Depends on ows_pkg.
module ows_seq_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  take,
   input  ows_pkg::seq_regs_type nxt,
   input  ows_pkg::rsp_type      rsp_next,
   output ows_pkg::seq_regs_type cur,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ows_pkg::rsp_type      rsp
);
   import ows_pkg::*;

   seq_regs_type regs_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_type      rsp_ff;

   // Step commits when the result slot is empty or being drained
   assign take      = item_valid && (!rsp_valid_ff || rsp_ready);
   assign cur       = regs_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.state       <= ST_IDLE;
         regs_ff.temp_tenths <= 16'sd0;
         regs_ff.busy        <= 1'b0;
         regs_ff.ready       <= 1'b0;
         regs_ff.error       <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (take) begin
            regs_ff <= nxt;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_next;
      end
   end

endmodule

FILE: sv/onewire_temp_sensor_sequencer.sv
// Top level of the one-wire temperature sensor sequencer.
// Depends on ows_pkg, ows_in_reg, ows_step and ows_seq_regs.
//
// Usage:
//   Request channel (req_*): each transaction is a start request or a step tick.
//   A tick carries the outcome of the bus operation issued on that tick
//   (presence, conversion done, scratchpad bytes 0 and 1).
//   Response channel (rsp_*): one transaction per request: the bus operation
//   and command byte to issue, the flags, state code and temperature in tenths
//   of a degree as they stand after the request.
//   Path: an accepted request is held in the input register, and its response
//   is captured in the result register (one input register, one result register).
//   Throughput: one request per cycle; the sequencer step is combinational
//   logic between the two registers, so back-to-back requests flow as long
//   as the response side takes one transaction per cycle.
//   Reset: synchronous, clears both stages, state to idle, flags and stored
//   temperature to zero.
//   Stall: a stalled response holds in the result register; one further
//   request waits in the input register, after which req_ready drops.
module onewire_temp_sensor_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic        req_presence_ok,
   input  logic        req_conversion_done,
   input  logic [7:0]  req_scratch_low_byte,
   input  logic [7:0]  req_scratch_high_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_bus_op,
   output logic [7:0]  rsp_bus_byte,
   output logic        rsp_start_accepted,
   output logic        rsp_busy_res,
   output logic        rsp_data_ready,
   output logic        rsp_error,
   output logic        rsp_complete,
   output logic [3:0]  rsp_state_code,
   output logic signed [15:0] rsp_temperature_x10
);
   import ows_pkg::*;

   item_type     req_item;
   item_type     item;
   logic         item_valid;
   logic         take;
   seq_regs_type cur;
   seq_regs_type nxt;
   rsp_type      rsp_next;
   rsp_type      rsp;

   assign req_item.action            = req_action;
   assign req_item.presence_ok       = req_presence_ok;
   assign req_item.conversion_done   = req_conversion_done;
   assign req_item.scratch_low_byte  = req_scratch_low_byte;
   assign req_item.scratch_high_byte = req_scratch_high_byte;

   ows_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ows_step u_step (
      .item (item),
      .cur  (cur),
      .nxt  (nxt),
      .rsp  (rsp_next)
   );

   ows_seq_regs u_seq_regs (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .take       (take),
      .nxt        (nxt),
      .rsp_next   (rsp_next),
      .cur        (cur),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // Response fields
   assign rsp_bus_op          = rsp.bus_op;
   assign rsp_bus_byte        = rsp.bus_byte;
   assign rsp_start_accepted  = rsp.start_accepted;
   assign rsp_busy_res        = rsp.busy_res;
   assign rsp_data_ready      = rsp.data_ready;
   assign rsp_error           = rsp.error;
   assign rsp_complete        = rsp.complete;
   assign rsp_state_code      = rsp.state_code;
   assign rsp_temperature_x10 = rsp.temperature_x10;

endmodule

FILE: sv/ows_checker.sv
// Port-level checker for the one-wire temperature sensor sequencer.
// Bound to onewire_temp_sensor_sequencer; depends on ows_pkg.
module ows_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_bus_op,
   input logic [7:0]         rsp_bus_byte,
   input logic               rsp_start_accepted,
   input logic               rsp_busy_res,
   input logic               rsp_data_ready,
   input logic               rsp_error,
   input logic               rsp_complete,
   input logic [3:0]         rsp_state_code,
   input logic signed [15:0] rsp_temperature_x10
);
   import ows_pkg::*;

   // Stalled response stays valid and holds its state code, bus operation and temperature
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_state_code)
         && $stable(rsp_bus_op) && $stable(rsp_temperature_x10))
      else $error("response changed while stalled");

   // Complete implies ready data in the complete state
   a_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_complete |-> rsp_data_ready && rsp_state_code == ST_COMPLETE)
      else $error("complete without ready data");

   // Error excludes busy and ready and shows the error state
   a_error_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_busy_res && !rsp_data_ready
         && rsp_state_code == ST_ERROR)
      else $error("error flag with busy or ready set");

   // Temperature is masked unless data is ready
   a_temp_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_ready |-> rsp_temperature_x10 == 16'sd0)
      else $error("temperature shown without ready data");

   // Accepted start arms the sequence and issues nothing on the bus
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_accepted |-> rsp_busy_res && rsp_bus_op == OP_NONE
         && rsp_bus_byte == CMD_NONE && rsp_state_code == ST_C_RESET)
      else $error("accepted start did not arm the sequence");

endmodule

bind onewire_temp_sensor_sequencer ows_checker u_ows_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_bus_op          (rsp_bus_op),
   .rsp_bus_byte        (rsp_bus_byte),
   .rsp_start_accepted  (rsp_start_accepted),
   .rsp_busy_res        (rsp_busy_res),
   .rsp_data_ready      (rsp_data_ready),
   .rsp_error           (rsp_error),
   .rsp_complete        (rsp_complete),
   .rsp_state_code      (rsp_state_code),
   .rsp_temperature_x10 (rsp_temperature_x10)
);

FILE: tb/tb.sv
// Self-checking testbench for the one-wire temperature sensor sequencer.
// Depends on ows_pkg and onewire_temp_sensor_sequencer; it predicts every response in
// step with the accepted requests and checks each field.
module tb;
   import ows_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int ITEM_TARGET    = 1450;
   localparam int DRAIN_INTERVAL = 300;

   // One queued request, optionally held until all responses are back
   typedef struct {
      item_type it;
      bit       hold;
   } send_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic        req_presence_ok = 1'b0;
   logic        req_conversion_done = 1'b0;
   logic [7:0]  req_scratch_low_byte = 8'h00;
   logic [7:0]  req_scratch_high_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_bus_op;
   logic [7:0]  rsp_bus_byte;
   logic        rsp_start_accepted;
   logic        rsp_busy_res;
   logic        rsp_data_ready;
   logic        rsp_error;
   logic        rsp_complete;
   logic [3:0]  rsp_state_code;
   logic signed [15:0] rsp_temperature_x10;

   send_entry_type items_to_send[$];
   rsp_type        step_results_due[$];
   seq_regs_type   plan_regs;      // sequencer copy used while building the stimulus
   seq_regs_type   model_regs;     // sequencer copy advanced by accepted requests
   logic           req_fire = 1'b0;
   int             items_accepted = 0;
   int             responses_checked = 0;
   int             runs_completed = 0;
   int             runs_faulted = 0;
   int             mismatches = 0;
   int             idle_cycles = 0;

   onewire_temp_sensor_sequencer i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_presence_ok       (req_presence_ok),
      .req_conversion_done   (req_conversion_done),
      .req_scratch_low_byte  (req_scratch_low_byte),
      .req_scratch_high_byte (req_scratch_high_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_bus_op            (rsp_bus_op),
      .rsp_bus_byte          (rsp_bus_byte),
      .rsp_start_accepted    (rsp_start_accepted),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_data_ready        (rsp_data_ready),
      .rsp_error             (rsp_error),
      .rsp_complete          (rsp_complete),
      .rsp_state_code        (rsp_state_code),
      .rsp_temperature_x10   (rsp_temperature_x10)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Missing presence or an unknown state: drop the run and flag it
   function automatic void enter_fault(inout seq_regs_type r);
      r.state = ST_ERROR;
      r.busy  = 1'b0;
      r.ready = 1'b0;
      r.error = 1'b1;
   endfunction

   // Advance the sequencer by one request and return the response it gives
   function automatic rsp_type sequencer_step(inout seq_regs_type r, input item_type it);
      rsp_type res;
      int      raw;
      res = '0;
      res.bus_op = OP_NONE;
      res.bus_byte = CMD_NONE;
      if (it.action == ACT_START) begin
         // a start is refused while a run is in flight
         if (!r.busy) begin
            r.state = ST_C_RESET;
            r.temp_tenths = '0;
            r.busy = 1'b1;
            r.ready = 1'b0;
            r.error = 1'b0;
            res.start_accepted = 1'b1;
         end
      end else begin
         case (r.state)
            ST_IDLE, ST_COMPLETE, ST_ERROR: ;
            ST_C_RESET, ST_R_RESET, ST_POST_RESET: begin
               res.bus_op = OP_RESET;
               if (!it.presence_ok) begin
                  enter_fault(r);
               end else if (r.state == ST_C_RESET) begin
                  r.state = ST_C_SKIP;
               end else if (r.state == ST_R_RESET) begin
                  r.state = ST_R_SKIP;
               end else begin
                  r.busy = 1'b0;
                  r.ready = 1'b1;
                  r.error = 1'b0;
                  r.state = ST_COMPLETE;
               end
            end
            ST_C_SKIP, ST_R_SKIP: begin
               res.bus_op = OP_WRITE;
               res.bus_byte = CMD_SKIP_ROM;
               r.state = (r.state == ST_C_SKIP) ? ST_C_CONV : ST_R_CMD;
            end
            ST_C_CONV: begin
               res.bus_op = OP_WRITE;
               res.bus_byte = CMD_CONVERT;
               r.state = ST_C_WAIT;
            end
            ST_C_WAIT: begin
               res.bus_op = OP_POLL;
               if (it.conversion_done) r.state = ST_R_RESET;
            end
            ST_R_CMD: begin
               res.bus_op = OP_WRITE;
               res.bus_byte = CMD_READ_PAD;
               r.state = ST_R_RECV;
            end
            ST_R_RECV: begin
               // tenths of a degree, division truncates toward zero
               res.bus_op = OP_READ;
               raw = $signed({it.scratch_high_byte, it.scratch_low_byte});
               r.temp_tenths = 16'(raw * 10 / 16);
               r.state = ST_POST_RESET;
            end
            default: begin
               enter_fault(r);
            end
         endcase
      end
      res.busy_res = r.busy;
      res.data_ready = r.ready;
      res.error = r.error;
      res.complete = (r.state == ST_COMPLETE) && r.ready;
      res.state_code = r.state;
      res.temperature_x10 = r.ready ? r.temp_tenths : 16'sd0;
      return res;
   endfunction

   // Build one request from explicit field values
   function automatic item_type make_item(logic act, logic pres, logic done,
                                          logic [7:0] lo, logic [7:0] hi);
      item_type it;
      it.action = act;
      it.presence_ok = pres;
      it.conversion_done = done;
      it.scratch_low_byte = lo;
      it.scratch_high_byte = hi;
      return it;
   endfunction

   // Fully random request; scratchpad words lean toward the range corners
   function automatic item_type random_item();
      item_type it;
      it.action = 1'($urandom_range(1));
      it.presence_ok = 1'($urandom_range(1));
      it.conversion_done = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0: {it.scratch_high_byte, it.scratch_low_byte} = 16'h8000;
            1: {it.scratch_high_byte, it.scratch_low_byte} = 16'h7FFF;
            2: {it.scratch_high_byte, it.scratch_low_byte} = 16'hFFFF;
            default: {it.scratch_high_byte, it.scratch_low_byte} = 16'h0000;
         endcase
      end else begin
         it.scratch_low_byte = 8'($urandom_range(255));
         it.scratch_high_byte = 8'($urandom_range(255));
      end
      return it;
   endfunction

   // Queue a request; returns 1 if it starts a run or issues a bus operation
   function automatic bit queue_item(item_type it, bit hold);
      rsp_type r;
      send_entry_type e;
      r = sequencer_step(plan_regs, it);
      e.it = it;
      e.hold = hold;
      items_to_send.push_back(e);
      return r.start_accepted || (r.bus_op != OP_NONE);
   endfunction

   task automatic log_mismatch(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         log_mismatch($sformatf("response %0d field %s: got 'h%h, expected 'h%h",
                                responses_checked, name, got, want));
   endtask

   // Driver: request and response ready change on the falling edge
   always @(negedge clock) begin
      int pct;
      send_entry_type e;
      // long stretch with no idling on either side
      pct = (items_accepted >= 500 && items_accepted < 800) ? 0 : 28;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= pct);
         if (!req_valid || req_fire) begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= pct &&
                !(items_to_send[0].hold && step_results_due.size() != 0)) begin
               e = items_to_send.pop_front();
               req_valid <= 1'b1;
               req_action <= e.it.action;
               req_presence_ok <= e.it.presence_ok;
               req_conversion_done <= e.it.conversion_done;
               req_scratch_low_byte <= e.it.scratch_low_byte;
               req_scratch_high_byte <= e.it.scratch_high_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on request transactions, check response transactions
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            want = sequencer_step(model_regs,
                                  make_item(req_action, req_presence_ok, req_conversion_done,
                                            req_scratch_low_byte, req_scratch_high_byte));
            step_results_due.push_back(want);
            items_accepted++;
            if (want.bus_op == OP_RESET && want.complete) runs_completed++;
            if (want.bus_op == OP_RESET && want.error) runs_faulted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (step_results_due.size() == 0) begin
               log_mismatch($sformatf("response %0d arrived with nothing expected",
                                      responses_checked));
            end else begin
               want = step_results_due.pop_front();
               check_field("bus_op", 16'(rsp_bus_op), 16'(want.bus_op));
               check_field("bus_byte", 16'(rsp_bus_byte), 16'(want.bus_byte));
               check_field("start_accepted", 16'(rsp_start_accepted),
                           16'(want.start_accepted));
               check_field("busy_res", 16'(rsp_busy_res), 16'(want.busy_res));
               check_field("data_ready", 16'(rsp_data_ready), 16'(want.data_ready));
               check_field("error", 16'(rsp_error), 16'(want.error));
               check_field("complete", 16'(rsp_complete), 16'(want.complete));
               check_field("state_code", 16'(rsp_state_code), 16'(want.state_code));
               check_field("temperature_x10", rsp_temperature_x10, want.temperature_x10);
            end
            responses_checked++;
         end
         // watchdog on cycles without any transaction
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("onewire_temp_sensor_sequencer regression: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      item_type it;
      int       effective;
      int       next_drain;
      bit       hold_next;
      plan_regs = '0;
      plan_regs.state = ST_IDLE;
      model_regs = plan_regs;

      // directed: idle tick, start with junk fields, refused start
      void'(queue_item(make_item(ACT_TICK, 1'b1, 1'b1, 8'hFF, 8'hFF), 1'b0));
      void'(queue_item(make_item(ACT_START, 1'b0, 1'b1, 8'hA5, 8'h5A), 1'b0));
      void'(queue_item(make_item(ACT_START, 1'b1, 1'b0, 8'h00, 8'h00), 1'b0));
      // full run with one poll not done, largest positive reading
      void'(queue_item(make_item(ACT_TICK, 1'b1, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b1, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b1, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b1, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b1, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'hFF, 8'h7F), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b1, 1'b0, 8'h00, 8'h00), 1'b0));
      // tick in complete, restart, missing presence, tick in error, restart
      void'(queue_item(make_item(ACT_TICK, 1'b1, 1'b1, 8'h12, 8'h34), 1'b0));
      void'(queue_item(make_item(ACT_START, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b1, 8'hFF, 8'hFF), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b1, 1'b1, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_START, 1'b1, 1'b1, 8'hFF, 8'hFF), 1'b0));
      // most negative reading, then no presence on the final reset
      void'(queue_item(make_item(ACT_TICK, 1'b1, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b1, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b1, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h80), 1'b0));
      void'(queue_item(make_item(ACT_TICK, 1'b0, 1'b0, 8'h00, 8'h00), 1'b0));

      // random: mostly well-formed runs, some noise; drain pauses at intervals
      effective = 0;
      next_drain = DRAIN_INTERVAL;
      hold_next = 1'b1;
      while (items_to_send.size() < ITEM_TARGET) begin
         it = random_item();
         if ($urandom_range(99) < 85) begin
            if (!plan_regs.busy)
               it.action = ($urandom_range(99) < 94) ? ACT_START : ACT_TICK;
            else
               it.action = ($urandom_range(99) < 3) ? ACT_START : ACT_TICK;
            it.presence_ok = ($urandom_range(99) < 93);
            it.conversion_done = ($urandom_range(99) < 40);
         end
         if (queue_item(it, hold_next)) effective++;
         hold_next = 1'b0;
         if (effective >= next_drain) begin
            hold_next = 1'b1;
            next_drain += DRAIN_INTERVAL;
         end
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (items_to_send.size() != 0 || req_valid || step_results_due.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (step_results_due.size() != 0)
         log_mismatch($sformatf("%0d expected responses never arrived",
                                step_results_due.size()));

      $display("covered %0d requests and %0d responses checked, %0d mismatches",
               items_accepted, responses_checked, mismatches);
      $display("sequences finished with a reading: %0d, ended on missing presence: %0d",
               runs_completed, runs_faulted);
      if (mismatches == 0)
         $display("onewire_temp_sensor_sequencer regression: pass");
      else
         $display("onewire_temp_sensor_sequencer regression: fail");
      $finish;
   end

endmodule

FILE: files.f
sv/ows_pkg.sv
sv/ows_in_reg.sv
sv/ows_step.sv
sv/ows_seq_regs.sv
sv/onewire_temp_sensor_sequencer.sv
sv/ows_checker.sv
tb/tb.sv
